@@ rtl/spmd_pkg.sv @@
// Shared types and constants for the six-channel PD motor duty core.
// Used by every module under rtl/; depends on nothing.
package spmd_pkg;

    localparam int DUTY_MAX = 8191;
    localparam int DUTY_W   = 13;
    localparam int SPD_W    = 16;
    localparam int ERR_W    = 17;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int POS_W    = 32;
    localparam int DB_W     = 31;
    localparam int GAIN_W   = 16;
    localparam int MAG_W    = 17;
    localparam int N_CH     = 6;
    localparam int IN_W     = 208;
    localparam int OUT_W    = 80;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 31;

    // register indexes on the configuration port
    localparam logic [CFG_A_W-1:0] REG_DRIVE_P  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_DRIVE_D  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ARM_TGT  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_ARM_P    = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ARM_D    = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_DEADBAND = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_TIMEOUT  = 3'd6;

    localparam logic signed [GAIN_W-1:0] RST_DRIVE_P  = 16'sd256;
    localparam logic signed [GAIN_W-1:0] RST_DRIVE_D  = 16'sd0;
    localparam logic [SPD_W-1:0]         RST_ARM_TGT  = 16'd28;
    localparam logic signed [GAIN_W-1:0] RST_ARM_P    = 16'sd256;
    localparam logic signed [GAIN_W-1:0] RST_ARM_D    = 16'sd0;
    localparam logic [DB_W-1:0]          RST_DEADBAND = 31'd66;
    localparam logic [SPD_W-1:0]         RST_TIMEOUT  = 16'd500;

    // per-stage load strobes from the top-level pipeline control
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } spmd_ctl_t;

endpackage

@@ rtl/spmd_lane.sv @@
// One PD channel: error difference, gain products, clamp and duty scaling.
// Four-stage pipeline driven by spmd_pkg::spmd_ctl_t strobes from the top level.
module spmd_lane (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  spmd_pkg::spmd_ctl_t                  ctl,
    input  logic                                 upd,
    input  logic signed [spmd_pkg::ERR_W-1:0]    err_in,
    input  logic                                 zero_in,
    input  logic signed [spmd_pkg::GAIN_W-1:0]   p_gain,
    input  logic signed [spmd_pkg::GAIN_W-1:0]   d_gain,
    output logic [spmd_pkg::DUTY_W-1:0]          duty
);
    import spmd_pkg::*;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int DP_W  = GAIN_W + DIFF_W;
    localparam int SUM_W = DP_W + 1;
    localparam int SC_W  = MAG_W + GAIN_W;
    localparam logic [GAIN_W-1:0] DUTY_K = GAIN_W'(DUTY_MAX);
    localparam logic signed [SUM_W-1:0] ONE_P = SUM_W'(65536);
    localparam logic signed [SUM_W-1:0] ONE_N = -SUM_W'(65536);

    logic signed [ERR_W-1:0]  last_reg;
    logic signed [ERR_W-1:0]  e1_reg;
    logic signed [DIFF_W-1:0] diff1_reg;
    logic                     zero1_reg;
    logic signed [PP_W-1:0]   pp2_reg;
    logic signed [DP_W-1:0]   dp2_reg;
    logic                     zero2_reg;
    logic [MAG_W-1:0]         mag3_reg;
    logic                     zero3_reg;
    logic [DUTY_W-1:0]        duty_reg;

    logic signed [DIFF_W-1:0] diff_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  clamp;
    logic [MAG_W-1:0]         mag_next;
    logic [SC_W-1:0]          scaled;

    assign diff_next = DIFF_W'(err_in) - DIFF_W'(last_reg);

    // last error is state: updated on every accepted tick the lane is live
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
        end else if (ctl.ld1 && upd) begin
            last_reg <= err_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            e1_reg    <= err_in;
            diff1_reg <= diff_next;
            zero1_reg <= zero_in;
        end
        if (ctl.ld2) begin
            pp2_reg   <= PP_W'(p_gain) * PP_W'(e1_reg);
            dp2_reg   <= DP_W'(d_gain) * DP_W'(diff1_reg);
            zero2_reg <= zero1_reg;
        end
        if (ctl.ld3) begin
            mag3_reg  <= mag_next;
            zero3_reg <= zero2_reg;
        end
        if (ctl.ld4) begin
            duty_reg  <= zero3_reg ? '0 : scaled[16 +: DUTY_W];
        end
    end

    // clamp to +/-1.0 in Q16.16 and take the magnitude
    always_comb begin
        sum = SUM_W'(pp2_reg) + SUM_W'(dp2_reg);
        if (sum > ONE_P) begin
            clamp = ONE_P;
        end else if (sum < ONE_N) begin
            clamp = ONE_N;
        end else begin
            clamp = sum;
        end
        mag_next = clamp[SUM_W-1] ? MAG_W'(-clamp) : MAG_W'(clamp);
    end

    assign scaled = SC_W'(mag3_reg) * SC_W'(DUTY_K);
    assign duty   = duty_reg;

endmodule

@@ rtl/spmd_arm_prep.sv @@
// Arm channel front end: speed error with saturation and position deadband test.
// Pure combinational; uses spmd_pkg widths.
module spmd_arm_prep (
    input  logic [spmd_pkg::SPD_W-1:0]          target,
    input  logic signed [spmd_pkg::SPD_W-1:0]   rpm,
    input  logic signed [spmd_pkg::POS_W-1:0]   pos_err,
    input  logic [spmd_pkg::DB_W-1:0]           deadband,
    output logic signed [spmd_pkg::ERR_W-1:0]   err,
    output logic                                in_band
);
    import spmd_pkg::*;

    localparam int FULL_W = ERR_W + 1;
    localparam logic signed [FULL_W-1:0] SAT_HI = FULL_W'(65535);
    localparam logic signed [FULL_W-1:0] SAT_LO = -FULL_W'(65536);

    logic signed [FULL_W-1:0] full;
    logic [POS_W-1:0]         pmag;

    assign full = $signed({2'b00, target}) - FULL_W'(rpm);

    always_comb begin
        if (full > SAT_HI) begin
            err = ERR_W'(SAT_HI);
        end else if (full < SAT_LO) begin
            err = ERR_W'(SAT_LO);
        end else begin
            err = ERR_W'(full);
        end
    end

    // most negative error wraps to 2^31 as unsigned, which is the wanted magnitude
    assign pmag    = pos_err[POS_W-1] ? POS_W'(-pos_err) : POS_W'(pos_err);
    assign in_band = !(pmag > {1'b0, deadband});

endmodule

@@ rtl/six_channel_pd_motor_duty_core.sv @@
// Six-channel PD motor duty core: four wheel lanes and two arm lanes in parallel.
// Throughput: one tick per cycle while m_tready is high; ready falls only when all four stages hold data.
// Reset (aresetn low, synchronous) loads the register defaults, clears the stored
// last errors and empties the pipeline. Depends on spmd_pkg, spmd_lane, spmd_arm_prep.
module six_channel_pd_motor_duty_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [spmd_pkg::CFG_A_W-1:0]   cfg_idx,
    input  logic [spmd_pkg::CFG_D_W-1:0]   cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // wheel_speed_left_front, wheel_speed_right_front, wheel_speed_left_rear,
    // wheel_speed_right_rear, left_target_speed, right_target_speed, left_arm_rpm,
    // right_arm_rpm, left_arm_pos_error, right_arm_pos_error, arm_data_age_ms
    input  logic [spmd_pkg::IN_W-1:0]      s_tdata,
    // arm_data_seen
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // duty_left_front, duty_right_front, duty_left_rear, duty_right_rear,
    // duty_left_arm, duty_right_arm, 2 zero pad bits
    output logic [spmd_pkg::OUT_W-1:0]     m_tdata,
    // arm_timed_out
    output logic                           m_tuser
);
    import spmd_pkg::*;

    logic signed [GAIN_W-1:0] drive_p_reg, drive_d_reg, arm_p_reg, arm_d_reg;
    logic [SPD_W-1:0]         arm_tgt_reg, timeout_reg;
    logic [DB_W-1:0]          deadband_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_p_reg  <= RST_DRIVE_P;
            drive_d_reg  <= RST_DRIVE_D;
            arm_tgt_reg  <= RST_ARM_TGT;
            arm_p_reg    <= RST_ARM_P;
            arm_d_reg    <= RST_ARM_D;
            deadband_reg <= RST_DEADBAND;
            timeout_reg  <= RST_TIMEOUT;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_DRIVE_P:  drive_p_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_DRIVE_D:  drive_d_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_ARM_TGT:  arm_tgt_reg  <= cfg_wdata[SPD_W-1:0];
                REG_ARM_P:    arm_p_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_ARM_D:    arm_d_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_DEADBAND: deadband_reg <= cfg_wdata[DB_W-1:0];
                REG_TIMEOUT:  timeout_reg  <= cfg_wdata[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- pipeline control: four stages, each may fill when the next drains
    logic [3:0]  vld_reg;
    logic [3:0]  tmo_reg;
    logic [3:0]  rdy;
    spmd_ctl_t   ctl;

    always_comb begin
        rdy[3] = !vld_reg[3] || m_tready;
        for (int k = 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ctl.ld1 = s_tvalid && rdy[0];
        ctl.ld2 = vld_reg[0] && rdy[1];
        ctl.ld3 = vld_reg[1] && rdy[2];
        ctl.ld4 = vld_reg[2] && rdy[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= ctl.ld1;
            if (rdy[1]) vld_reg[1] <= ctl.ld2;
            if (rdy[2]) vld_reg[2] <= ctl.ld3;
            if (rdy[3]) vld_reg[3] <= ctl.ld4;
        end
    end

    // ---- input unpacking
    logic signed [SPD_W-1:0] ws [4];
    logic signed [SPD_W-1:0] tgt_l, tgt_r, rpm_l, rpm_r;
    logic signed [POS_W-1:0] pos_l, pos_r;
    logic [SPD_W-1:0]        age;
    logic                    timed_out;

    assign ws[0] = s_tdata[15:0];
    assign ws[1] = s_tdata[31:16];
    assign ws[2] = s_tdata[47:32];
    assign ws[3] = s_tdata[63:48];
    assign tgt_l = s_tdata[79:64];
    assign tgt_r = s_tdata[95:80];
    assign rpm_l = s_tdata[111:96];
    assign rpm_r = s_tdata[127:112];
    assign pos_l = s_tdata[159:128];
    assign pos_r = s_tdata[191:160];
    assign age   = s_tdata[207:192];

    assign timed_out = !s_tuser || (age > timeout_reg);

    always_ff @(posedge aclk) begin
        if (ctl.ld1) tmo_reg[0] <= timed_out;
        if (ctl.ld2) tmo_reg[1] <= tmo_reg[0];
        if (ctl.ld3) tmo_reg[2] <= tmo_reg[1];
        if (ctl.ld4) tmo_reg[3] <= tmo_reg[2];
    end

    // ---- lanes
    logic [DUTY_W-1:0]       duty [N_CH];
    logic signed [ERR_W-1:0] w_err [4];
    logic signed [ERR_W-1:0] a_err [2];
    logic                    a_band [2];

    // left target feeds both left wheels, right target both right wheels
    assign w_err[0] = ERR_W'(ws[0]) - ERR_W'(tgt_l);
    assign w_err[1] = ERR_W'(ws[1]) - ERR_W'(tgt_r);
    assign w_err[2] = ERR_W'(ws[2]) - ERR_W'(tgt_l);
    assign w_err[3] = ERR_W'(ws[3]) - ERR_W'(tgt_r);

    for (genvar i = 0; i < 4; i++) begin : g_wheel
        spmd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .upd     (1'b1),
            .err_in  (w_err[i]),
            .zero_in (1'b0),
            .p_gain  (drive_p_reg),
            .d_gain  (drive_d_reg),
            .duty    (duty[i])
        );
    end

    spmd_arm_prep u_prep_l (
        .target   (arm_tgt_reg),
        .rpm      (rpm_l),
        .pos_err  (pos_l),
        .deadband (deadband_reg),
        .err      (a_err[0]),
        .in_band  (a_band[0])
    );

    spmd_arm_prep u_prep_r (
        .target   (arm_tgt_reg),
        .rpm      (rpm_r),
        .pos_err  (pos_r),
        .deadband (deadband_reg),
        .err      (a_err[1]),
        .in_band  (a_band[1])
    );

    // a timeout leaves the arm memory untouched
    for (genvar i = 0; i < 2; i++) begin : g_arm
        spmd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .upd     (!timed_out),
            .err_in  (a_err[i]),
            .zero_in (timed_out || a_band[i]),
            .p_gain  (arm_p_reg),
            .d_gain  (arm_d_reg),
            .duty    (duty[4+i])
        );
    end

    // ---- merge: lane outputs are the output register
    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[3];
    assign m_tuser  = tmo_reg[3];
    assign m_tdata  = {2'b00, duty[5], duty[4], duty[3], duty[2], duty[1], duty[0]};

endmodule

@@ rtl/spmd_checker.sv @@
// Port-level checks for six_channel_pd_motor_duty_core, attached by bind below.
// Depends on spmd_pkg for port widths.
module spmd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [spmd_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           m_tuser
);
    import spmd_pkg::*;

    logic [2:0] inflight_reg;
    logic       s_xfer, m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + 3'(s_xfer) - 3'(m_xfer);
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transfer dropped while stalled");

    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 3'd0)
        else $error("result without an accepted tick");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd4)
        else $error("more ticks in flight than pipeline stages");

    a_arm_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[77:52] == 26'd0)
        else $error("arm duty nonzero on timeout");

endmodule

bind six_channel_pd_motor_duty_core spmd_checker u_spmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
